@@ design/pffe_pkg.sv @@
`timescale 1ns / 1ps

package pffe_pkg;

   // Default display geometry
   localparam int DisplayColumnsDefault = 128;
   localparam int DisplayPagesDefault   = 8;

   // Payload field widths
   localparam int OpWidth     = 3;
   localparam int PageWidth   = 3;
   localparam int ColumnWidth = 7;
   localparam int OffsetWidth = 3;
   localparam int SpanWWidth  = 8;
   localparam int SpanHWidth  = 4;
   localparam int ByteWidth   = 8;

   // Command codes
   localparam logic [OpWidth-1:0] OP_SET_BAND   = 3'd0;
   localparam logic [OpWidth-1:0] OP_CLEAR_BAND = 3'd1;
   localparam logic [OpWidth-1:0] OP_CLEAR_ALL  = 3'd2;
   localparam logic [OpWidth-1:0] OP_WRITE_BYTE = 3'd3;
   localparam logic [OpWidth-1:0] OP_READ_BYTE  = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic load;         // capture the accepted item
      logic clear_start;  // restart the sweep address at zero
      logic clear_step;   // write zero at the sweep address, advance
      logic fill_step;    // read one band column, advance
      logic write_byte;   // store the captured byte
      logic read_issue;   // read the addressed column byte
      logic rsp_load;     // move the read byte into the output register
   } pffe_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic addr_last;    // sweep address is at the last store byte
      logic cnt_zero;     // no band columns left
      logic cnt_one;      // one band column left
      logic rsp_free;     // output register can take a byte this cycle
   } pffe_status_type;

   // Mask of bits offset .. offset+height-1, bits above 7 dropped
   function automatic logic [ByteWidth-1:0] band_mask(
      input logic [OffsetWidth-1:0] offset,
      input logic [SpanHWidth-1:0]  height
   );
      logic [ByteWidth-1:0] m;
      logic [4:0]           top;
      m   = '0;
      top = 5'(offset) + 5'(height);
      for (int b = 0; b < ByteWidth; b++) begin
         m[b] = (5'(b) >= 5'(offset)) && (5'(b) < top);
      end
      return m;
   endfunction

endpackage

@@ design/pffe_if.sv @@
`timescale 1ns / 1ps

interface pffe_req_if;
   logic                           valid;
   logic                           ready;
   logic [pffe_pkg::OpWidth-1:0]     op;
   logic [pffe_pkg::PageWidth-1:0]   page;
   logic [pffe_pkg::ColumnWidth-1:0] column;
   logic [pffe_pkg::OffsetWidth-1:0] bit_offset;
   logic [pffe_pkg::SpanWWidth-1:0]  span_width;
   logic [pffe_pkg::SpanHWidth-1:0]  span_height;
   logic [pffe_pkg::ByteWidth-1:0]   write_data;

   modport source (
      output valid, op, page, column, bit_offset, span_width, span_height, write_data,
      input  ready
   );
   modport sink (
      input  valid, op, page, column, bit_offset, span_width, span_height, write_data,
      output ready
   );
endinterface

interface pffe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pffe_pkg::ByteWidth-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

@@ design/pffe_ctrl.sv @@
`timescale 1ns / 1ps

module pffe_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [pffe_pkg::OpWidth-1:0] req_op,
   output logic                         req_ready,
   input  pffe_pkg::pffe_status_type    status,
   output pffe_pkg::pffe_cmd_type       cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_op)
                  pffe_pkg::OP_SET_BAND, pffe_pkg::OP_CLEAR_BAND: state_in = ST_FILL;
                  pffe_pkg::OP_CLEAR_ALL: begin
                     cmd.clear_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  pffe_pkg::OP_WRITE_BYTE: state_in = ST_WRITE;
                  pffe_pkg::OP_READ_BYTE:  state_in = ST_READ;
                  default:                 state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            if (status.cnt_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.fill_step = 1'b1;
               if (status.cnt_one) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: state_in = ST_IDLE;
         ST_WRITE: begin
            cmd.write_byte = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/pffe_datapath.sv @@
`timescale 1ns / 1ps

module pffe_datapath #(
   parameter int DISPLAY_COLUMNS = pffe_pkg::DisplayColumnsDefault,
   parameter int DISPLAY_PAGES   = pffe_pkg::DisplayPagesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pffe_pkg::PageWidth-1:0]   req_page,
   input  logic [pffe_pkg::ColumnWidth-1:0] req_column,
   input  logic [pffe_pkg::OffsetWidth-1:0] req_bit_offset,
   input  logic [pffe_pkg::SpanWWidth-1:0]  req_span_width,
   input  logic [pffe_pkg::SpanHWidth-1:0]  req_span_height,
   input  logic [pffe_pkg::ByteWidth-1:0]   req_write_data,
   input  logic [pffe_pkg::OpWidth-1:0]     req_op,
   input  pffe_pkg::pffe_cmd_type           cmd,
   output pffe_pkg::pffe_status_type        status,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [pffe_pkg::ByteWidth-1:0]   rsp_read_data
);

   localparam int Depth = DISPLAY_PAGES * DISPLAY_COLUMNS;
   localparam int AddrW = $clog2(Depth);
   localparam int CntW  = $clog2(DISPLAY_COLUMNS + 1);
   localparam int BW    = pffe_pkg::ByteWidth;

   logic [BW-1:0] mem [Depth];

   logic [AddrW-1:0] addr_ff, addr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [BW-1:0]    mask_ff, data_ff;
   logic             hit_ff, set_ff;
   logic             rmw_valid_ff, rmw_valid_in;
   logic [AddrW-1:0] rmw_addr_ff;
   logic [BW-1:0]    rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]    rsp_data_ff;

   logic             req_hit;
   logic [9:0]       room;
   logic [9:0]       span;
   logic [CntW-1:0]  req_count;
   logic [AddrW-1:0] req_base;

   logic             mem_we;
   logic [AddrW-1:0] mem_waddr;
   logic [BW-1:0]    mem_wdata;
   logic             mem_re;

   // Decode the item: range check, clipped span length, base address
   always_comb begin
      req_hit  = (32'(req_page) < DISPLAY_PAGES) && (32'(req_column) < DISPLAY_COLUMNS);
      room     = 10'(DISPLAY_COLUMNS) - 10'(req_column);
      span     = 10'(req_span_width);
      req_base = AddrW'(32'(req_page) * DISPLAY_COLUMNS + 32'(req_column));
      if (!req_hit || req_span_height == '0) begin
         req_count = '0;
      end else if (span < room) begin
         req_count = CntW'(span);
      end else begin
         req_count = CntW'(room);
      end
   end

   // Sweep address and band counter
   always_comb begin
      addr_in      = addr_ff;
      count_in     = count_ff;
      rmw_valid_in = 1'b0;
      if (cmd.clear_start) begin
         addr_in = '0;
      end else if (cmd.load) begin
         addr_in  = req_base;
         count_in = req_count;
      end else if (cmd.clear_step || cmd.fill_step) begin
         addr_in = addr_ff + AddrW'(1);
      end
      if (cmd.fill_step) begin
         count_in     = count_ff - CntW'(1);
         rmw_valid_in = 1'b1;
      end
   end

   // Write port: pending read-modify-write first, then sweep, then byte store
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (rmw_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = rmw_addr_ff;
         mem_wdata = set_ff ? (rd_data_ff | mask_ff) : (rd_data_ff & ~mask_ff);
      end else if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.write_byte && hit_ff) begin
         mem_we    = 1'b1;
         mem_wdata = data_ff;
      end
      mem_re = cmd.fill_step || (cmd.read_issue && hit_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         count_ff     <= '0;
         rmw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rmw_valid_ff <= rmw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= pffe_pkg::band_mask(req_bit_offset, req_span_height);
         data_ff <= req_write_data;
         hit_ff  <= req_hit;
         set_ff  <= (req_op == pffe_pkg::OP_SET_BAND);
      end
      if (cmd.fill_step) begin
         rmw_addr_ff <= addr_ff;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= hit_ff ? rd_data_ff : '0;
      end
   end

   assign status.addr_last = (addr_ff == AddrW'(Depth - 1));
   assign status.cnt_zero  = (count_ff == '0);
   assign status.cnt_one   = (count_ff == CntW'(1));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

@@ design/page_framebuffer_fill_engine_top.sv @@
`timescale 1ns / 1ps

// Monochrome page frame store, DISPLAY_PAGES pages by DISPLAY_COLUMNS column
// bytes, bit k of a byte being pixel row k of its page. Items arrive on req_bus;
// only a read byte item returns an item on rsp_bus. Set or clear band walks n
// column bytes, where n is the span clipped at the right edge (zero for an
// empty band or an address off the display); the store has one read and one
// write port and the band walks it one column byte per cycle with a
// read-modify-write. Read byte waits while a previous byte still waits in the
// output register. Clear all sweeps the DISPLAY_PAGES * DISPLAY_COLUMNS store
// bytes one byte per cycle; the same sweep runs right after reset;
// req_bus.ready stays low during it. A read of a page or column off the
// display returns 0; unknown ops are dropped without a result.

module page_framebuffer_fill_engine_top #(
   parameter int DISPLAY_COLUMNS = pffe_pkg::DisplayColumnsDefault,
   parameter int DISPLAY_PAGES   = pffe_pkg::DisplayPagesDefault
) (
   input logic       clock,
   input logic       reset,
   pffe_req_if.sink  req_bus,
   pffe_rsp_if.source rsp_bus
);

   pffe_pkg::pffe_cmd_type    cmd;
   pffe_pkg::pffe_status_type status;

   // Sequencer: owns the request handshake and the order of store accesses
   pffe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, address walker, mask logic and the output register
   pffe_datapath #(
      .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
      .DISPLAY_PAGES   (DISPLAY_PAGES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_page        (req_bus.page),
      .req_column      (req_bus.column),
      .req_bit_offset  (req_bus.bit_offset),
      .req_span_width  (req_bus.span_width),
      .req_span_height (req_bus.span_height),
      .req_write_data  (req_bus.write_data),
      .req_op          (req_bus.op),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_read_data   (rsp_bus.read_data)
   );

`ifndef SYNTHESIS
   // At most one store access of the sequencer per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.fill_step, cmd.write_byte, cmd.read_issue}))
      else $error("conflicting store commands");

   // No item is taken while a band walks the store
   assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> !req_bus.ready)
      else $error("item accepted during band fill");

   // A waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result overwritten");
`endif

endmodule
